// ===== rtl/lrut_pkg.sv =====
// Shared constants and types for the LRU cache tracker.
package lrut_pkg;

    localparam int KEY_W         = 32;
    localparam int CFG_W         = 5;
    localparam int IDX_OUT_W     = 4;
    localparam int HITS_W        = 32;
    localparam int MAX_SLOTS_DEF = 16;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

    // Command broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic clear;      // empty the slot
        logic update;     // apply the recency update of one access
        logic age_all;    // age every other filled slot (miss case)
        logic write_key;  // target slot takes the new key
    } cell_cmd_t;

endpackage

// ===== rtl/lru_replacement_cache_tracker_top.sv =====
// Top level of the fully associative LRU cache tracker: control, counters and stream ports.
//
//   Port group   Direction   Item contents
//   s_*          in          tdata: access_key[31:0]; tuser: start_run[0]
//   m_*          out         tdata: hit, slot_index, evicted, evicted_key, hit_count
//   cfg_*        in          active_slots, written when cfg_we is high
//
// Each item passes the states SEED, SCAN and COMMIT: the lookup token is launched in SEED
// and passes every cell of the row (it enters the first cell at the end of the launch
// cycle), the result is captured from the tail cell, and the recency update is committed.
// The input is ready again only after the commit, so one item is handled at a time.
// Reset empties every slot, clears the hit count and sets active_slots to 16.
// A result waits in the output register while m_tready is low; the next item is
// taken meanwhile, and its commit waits until that register is free.
module lru_replacement_cache_tracker_top
    import lrut_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // access_key[31:0]
    input  logic [0:0]       s_tuser,   // start_run[0]
    output logic             m_tvalid,
    input  logic             m_tready,
    // hit[0], slot_index[4:1], evicted[5], evicted_key[37:6], hit_count[69:38], zero[71:70]
    output logic [71:0]      m_tdata,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int RW = IW;
    localparam int FW = $clog2(MAX_SLOTS + 1);
    localparam int LW = (FW > CFG_W) ? FW : CFG_W;
    localparam logic [LW-1:0] MAX_EXT = LW'(MAX_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t            state_reg;
    logic [CFG_W-1:0]  active_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [FW-1:0]     filled_reg;
    logic [HITS_W-1:0] hits_reg;
    logic              res_found_reg;
    logic [IW-1:0]     res_hit_idx_reg;
    logic [RW-1:0]     res_hit_rank_reg;
    logic [IW-1:0]     res_lru_idx_reg;
    logic [KEY_W-1:0]  res_lru_key_reg;
    logic              m_tvalid_reg;
    logic [71:0]       m_tdata_reg;

    logic              in_accept;
    logic              commit_go;
    logic [LW-1:0]     act_ext;
    logic [LW-1:0]     limit;
    logic              is_fill;
    logic              is_evict;
    logic [IW-1:0]     target;
    logic [IW+3:0]     target_wide;
    logic [HITS_W-1:0] hits_next;
    logic [KEY_W-1:0]  ev_key;
    logic [71:0]       result;
    cell_cmd_t         cmd;

    logic              tail_act;
    logic              tail_found;
    logic [IW-1:0]     tail_hit_idx;
    logic [RW-1:0]     tail_hit_rank;
    logic [IW-1:0]     tail_lru_idx;
    logic [KEY_W-1:0]  tail_lru_key;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign commit_go = (state_reg == ST_COMMIT) && (!m_tvalid_reg || m_tready);

    // An out-of-range limit is clamped to the range 1 .. MAX_SLOTS.
    always_comb
    begin
        act_ext = LW'(active_reg);
        if (act_ext == '0)
        begin
            limit = LW'(1);
        end
        else if (act_ext > MAX_EXT)
        begin
            limit = MAX_EXT;
        end
        else
        begin
            limit = act_ext;
        end
    end

    always_comb
    begin
        is_fill  = !res_found_reg && (LW'(filled_reg) < limit);
        is_evict = !res_found_reg && !is_fill;
        if (res_found_reg)
        begin
            target = res_hit_idx_reg;
        end
        else if (is_fill)
        begin
            target = filled_reg[IW-1:0];
        end
        else
        begin
            target = res_lru_idx_reg;
        end
        target_wide = {4'b0000, target};
        ev_key      = is_evict ? res_lru_key_reg : '0;
        hits_next   = (res_found_reg && (hits_reg != '1)) ? hits_reg + 1'b1 : hits_reg;
        result      = {2'b00, hits_next, ev_key, is_evict, target_wide[IDX_OUT_W-1:0],
                       res_found_reg};
    end

    always_comb
    begin
        cmd.clear     = in_accept && s_tuser[0];
        cmd.update    = commit_go;
        cmd.age_all   = !res_found_reg;
        cmd.write_key = !res_found_reg;
    end

    lrut_chain #(
        .MAX_SLOTS (MAX_SLOTS),
        .IW        (IW),
        .RW        (RW)
    ) u_chain (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .key_in        (key_reg),
        .target        (target),
        .below         (res_hit_rank_reg),
        .seed          (state_reg == ST_SEED),
        .tail_act      (tail_act),
        .tail_found    (tail_found),
        .tail_hit_idx  (tail_hit_idx),
        .tail_hit_rank (tail_hit_rank),
        .tail_lru_idx  (tail_lru_idx),
        .tail_lru_key  (tail_lru_key)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            active_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            key_reg          <= '0;
            filled_reg       <= '0;
            hits_reg         <= '0;
            res_found_reg    <= 1'b0;
            res_hit_idx_reg  <= '0;
            res_hit_rank_reg <= '0;
            res_lru_idx_reg  <= '0;
            res_lru_key_reg  <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !commit_go)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        key_reg   <= s_tdata;
                        state_reg <= ST_SEED;
                        if (s_tuser[0])
                        begin
                            filled_reg <= '0;
                            hits_reg   <= '0;
                        end
                    end
                end
                ST_SEED:
                begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (tail_act)
                    begin
                        res_found_reg    <= tail_found;
                        res_hit_idx_reg  <= tail_hit_idx;
                        res_hit_rank_reg <= tail_hit_rank;
                        res_lru_idx_reg  <= tail_lru_idx;
                        res_lru_key_reg  <= tail_lru_key;
                        state_reg        <= ST_COMMIT;
                    end
                end
                ST_COMMIT:
                begin
                    if (commit_go)
                    begin
                        hits_reg     <= hits_next;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= result;
                        state_reg    <= ST_IDLE;
                        if (is_fill)
                        begin
                            filled_reg <= filled_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/lrut_cell.sv =====
// One cache slot: stored key, age rank and fill flag, plus its stage of the lookup token.
module lrut_cell
    import lrut_pkg::*;
#(
    parameter int IW      = 4,
    parameter int RW      = 4,
    parameter int CELL_ID = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [KEY_W-1:0] key_in,
    input  logic [IW-1:0]    target,
    input  logic [RW-1:0]    below,
    input  logic             act_in,
    input  logic             found_in,
    input  logic [IW-1:0]    hit_idx_in,
    input  logic [RW-1:0]    hit_rank_in,
    input  logic             have_lru_in,
    input  logic [IW-1:0]    lru_idx_in,
    input  logic [RW-1:0]    lru_rank_in,
    input  logic [KEY_W-1:0] lru_key_in,
    output logic             act_out,
    output logic             found_out,
    output logic [IW-1:0]    hit_idx_out,
    output logic [RW-1:0]    hit_rank_out,
    output logic             have_lru_out,
    output logic [IW-1:0]    lru_idx_out,
    output logic [RW-1:0]    lru_rank_out,
    output logic [KEY_W-1:0] lru_key_out
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_ID);

    logic             valid_reg;
    logic             valid_next;
    logic [RW-1:0]    rank_reg;
    logic [RW-1:0]    rank_next;
    logic [KEY_W-1:0] key_reg;

    logic             act_reg;
    logic             found_reg;
    logic             found_next;
    logic [IW-1:0]    hit_idx_reg;
    logic [IW-1:0]    hit_idx_next;
    logic [RW-1:0]    hit_rank_reg;
    logic [RW-1:0]    hit_rank_next;
    logic             have_lru_reg;
    logic             have_lru_next;
    logic [IW-1:0]    lru_idx_reg;
    logic [IW-1:0]    lru_idx_next;
    logic [RW-1:0]    lru_rank_reg;
    logic [RW-1:0]    lru_rank_next;
    logic [KEY_W-1:0] lru_key_reg;
    logic [KEY_W-1:0] lru_key_next;

    logic is_target;
    logic take_hit;
    logic take_lru;

    assign is_target = (target == MY_IDX);

    // The token keeps the first matching slot and the oldest filled slot seen so far.
    always_comb
    begin
        take_hit = act_in && !found_in && valid_reg && (key_reg == key_in);
        take_lru = act_in && valid_reg && (!have_lru_in || (rank_reg > lru_rank_in));

        found_next    = found_in | take_hit;
        hit_idx_next  = take_hit ? MY_IDX : hit_idx_in;
        hit_rank_next = take_hit ? rank_reg : hit_rank_in;
        have_lru_next = have_lru_in | take_lru;
        lru_idx_next  = take_lru ? MY_IDX : lru_idx_in;
        lru_rank_next = take_lru ? rank_reg : lru_rank_in;
        lru_key_next  = take_lru ? key_reg : lru_key_in;
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
            rank_next  = '0;
        end
        else if (cmd.update)
        begin
            if (is_target)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
            end
            else if (valid_reg && (cmd.age_all || (rank_reg < below)))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            rank_reg     <= '0;
            act_reg      <= 1'b0;
            found_reg    <= 1'b0;
            have_lru_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rank_reg     <= rank_next;
            act_reg      <= act_in;
            found_reg    <= found_next;
            have_lru_reg <= have_lru_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && is_target && cmd.write_key)
        begin
            key_reg <= key_in;
        end
        hit_idx_reg  <= hit_idx_next;
        hit_rank_reg <= hit_rank_next;
        lru_idx_reg  <= lru_idx_next;
        lru_rank_reg <= lru_rank_next;
        lru_key_reg  <= lru_key_next;
    end

    assign act_out      = act_reg;
    assign found_out    = found_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign hit_rank_out = hit_rank_reg;
    assign have_lru_out = have_lru_reg;
    assign lru_idx_out  = lru_idx_reg;
    assign lru_rank_out = lru_rank_reg;
    assign lru_key_out  = lru_key_reg;

endmodule

// ===== rtl/lrut_chain.sv =====
// Row of slot cells through which the lookup token travels one cell per cycle.
module lrut_chain
    import lrut_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int IW        = 4,
    parameter int RW        = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [KEY_W-1:0] key_in,
    input  logic [IW-1:0]    target,
    input  logic [RW-1:0]    below,
    input  logic             seed,
    output logic             tail_act,
    output logic             tail_found,
    output logic [IW-1:0]    tail_hit_idx,
    output logic [RW-1:0]    tail_hit_rank,
    output logic [IW-1:0]    tail_lru_idx,
    output logic [KEY_W-1:0] tail_lru_key
);

    logic             act      [MAX_SLOTS+1];
    logic             found    [MAX_SLOTS+1];
    logic [IW-1:0]    hit_idx  [MAX_SLOTS+1];
    logic [RW-1:0]    hit_rank [MAX_SLOTS+1];
    logic             have_lru [MAX_SLOTS+1];
    logic [IW-1:0]    lru_idx  [MAX_SLOTS+1];
    logic [RW-1:0]    lru_rank [MAX_SLOTS+1];
    logic [KEY_W-1:0] lru_key  [MAX_SLOTS+1];

    assign act[0]      = seed;
    assign found[0]    = 1'b0;
    assign hit_idx[0]  = '0;
    assign hit_rank[0] = '0;
    assign have_lru[0] = 1'b0;
    assign lru_idx[0]  = '0;
    assign lru_rank[0] = '0;
    assign lru_key[0]  = '0;

    for (genvar i = 0; i < MAX_SLOTS; i++)
    begin : g_cell
        lrut_cell #(
            .IW      (IW),
            .RW      (RW),
            .CELL_ID (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .key_in       (key_in),
            .target       (target),
            .below        (below),
            .act_in       (act[i]),
            .found_in     (found[i]),
            .hit_idx_in   (hit_idx[i]),
            .hit_rank_in  (hit_rank[i]),
            .have_lru_in  (have_lru[i]),
            .lru_idx_in   (lru_idx[i]),
            .lru_rank_in  (lru_rank[i]),
            .lru_key_in   (lru_key[i]),
            .act_out      (act[i+1]),
            .found_out    (found[i+1]),
            .hit_idx_out  (hit_idx[i+1]),
            .hit_rank_out (hit_rank[i+1]),
            .have_lru_out (have_lru[i+1]),
            .lru_idx_out  (lru_idx[i+1]),
            .lru_rank_out (lru_rank[i+1]),
            .lru_key_out  (lru_key[i+1])
        );
    end

    assign tail_act      = act[MAX_SLOTS];
    assign tail_found    = found[MAX_SLOTS];
    assign tail_hit_idx  = hit_idx[MAX_SLOTS];
    assign tail_hit_rank = hit_rank[MAX_SLOTS];
    assign tail_lru_idx  = lru_idx[MAX_SLOTS];
    assign tail_lru_key  = lru_key[MAX_SLOTS];

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the LRU cache tracker: directed table, then random lookup phases.
`timescale 1ns / 1ps

module tb;
    import lrut_pkg::*;

    localparam int NSLOT     = MAX_SLOTS_DEF;
    localparam int LIMIT     = 400000;
    localparam int PHASES    = 12;
    localparam int PER_PH    = 145;
    localparam int HOLD_CY   = 300;
    localparam int ALL_AGE   = 1 << 30;
    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic        evicted;
        logic [31:0] ev_key;
        logic [31:0] hits;
    } lookup_t;

    typedef enum bit {ROW_ACCESS, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [4:0]  cfg;
        logic        st;
        logic [31:0] key;
        logic        typed;
        lookup_t     want;
    } row_t;

    localparam lookup_t NO_WANT = '0;
    localparam int NROWS = 23;

    // Rows with typed results can be read off directly; the rest use the predictor.
    localparam row_t STIM [NROWS] = '{
        '{ROW_ACCESS, 5'd0, 1'b0, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, 1'b0, 32'h0, 32'd0}},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 32'h0, 32'd0}},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'h0000_0000, 1'b1, '{1'b1, 4'd0, 1'b0, 32'h0, 32'd1}},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd1, 1'b0, 32'h0, 32'd2}},
        '{ROW_ACCESS, 5'd0, 1'b1, 32'hAAAA_AAAA, 1'b1, '{1'b0, 4'd0, 1'b0, 32'h0, 32'd0}},
        '{ROW_CFG,    5'd0, 1'b0, 32'h0,         1'b0, NO_WANT},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'h5555_5555, 1'b1,
          '{1'b0, 4'd0, 1'b1, 32'hAAAA_AAAA, 32'd0}},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'h5555_5555, 1'b1, '{1'b1, 4'd0, 1'b0, 32'h0, 32'd1}},
        '{ROW_CFG,    5'd31, 1'b0, 32'h0,        1'b0, NO_WANT},
        '{ROW_ACCESS, 5'd0, 1'b1, 32'h0000_0001, 1'b1, '{1'b0, 4'd0, 1'b0, 32'h0, 32'd0}},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'h0000_0002, 1'b0, NO_WANT},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'h0000_0003, 1'b0, NO_WANT},
        '{ROW_CFG,    5'd2, 1'b0, 32'h0,         1'b0, NO_WANT},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'h0000_0004, 1'b0, NO_WANT},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'h0000_0002, 1'b0, NO_WANT},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'h0000_0005, 1'b0, NO_WANT},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'h0000_0003, 1'b0, NO_WANT},
        '{ROW_CFG,    5'd16, 1'b0, 32'h0,        1'b0, NO_WANT},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'hC3C3_C3C3, 1'b0, NO_WANT},
        '{ROW_CFG,    5'd1, 1'b0, 32'h0,         1'b0, NO_WANT},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'h0000_0006, 1'b0, NO_WANT},
        '{ROW_ACCESS, 5'd0, 1'b0, 32'h0000_0006, 1'b0, NO_WANT},
        '{ROW_CFG,    5'd16, 1'b0, 32'h0,        1'b0, NO_WANT}
    };

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [31:0]      s_tdata;
    logic [0:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [71:0]      m_tdata;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    lru_replacement_cache_tracker_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state: directory contents, recency ranks, fill level, hit count.
    logic [31:0]      dir_key [NSLOT];
    int               dir_rank [NSLOT];
    int               dir_filled;
    logic [31:0]      dir_hits;
    logic [CFG_W-1:0] slot_cfg;

    // Expected results in order of acceptance, kept as a ring with free-running counters.
    lookup_t     exp_buf [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;
    lookup_t     got_r;
    lookup_t     want_r;
    int          errors;
    int          items_sent;
    int          hits_seen;
    int          evicts_seen;
    int          cfg_writes;
    int          cycles;
    bit          calm;
    bit          hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Age every filled slot younger than the given rank, then make the slot newest.
    function automatic void make_newest(input int slot, input int below);
        int k;
        for (k = 0; k < dir_filled; k++)
            if (k != slot && dir_rank[k] < below)
                dir_rank[k]++;
        dir_rank[slot] = 0;
    endfunction

    function automatic lookup_t cache_lookup(input logic st, input logic [31:0] key);
        lookup_t r;
        int      lim;
        int      slot;
        int      k;
        bit      found;
        r     = '0;
        found = 1'b0;
        slot  = 0;
        lim   = (slot_cfg == 0) ? 1 : ((slot_cfg > NSLOT) ? NSLOT : int'(slot_cfg));
        if (st)
        begin
            dir_filled = 0;
            dir_hits   = '0;
            for (k = 0; k < NSLOT; k++)
                dir_rank[k] = 0;
        end
        for (k = 0; k < dir_filled; k++)
            if (!found && dir_key[k] == key)
            begin
                found = 1'b1;
                slot  = k;
            end
        if (found)
        begin
            if (dir_hits != 32'hFFFF_FFFF)
                dir_hits++;
            make_newest(slot, dir_rank[slot]);
        end
        else if (dir_filled < lim)
        begin
            slot = dir_filled;
            dir_filled++;
            dir_key[slot] = key;
            make_newest(slot, ALL_AGE);
        end
        else
        begin
            // Full, or the limit was lowered below the fill level: replace the oldest slot.
            for (k = 1; k < dir_filled; k++)
                if (dir_rank[k] > dir_rank[slot])
                    slot = k;
            r.evicted     = 1'b1;
            r.ev_key      = dir_key[slot];
            dir_key[slot] = key;
            make_newest(slot, ALL_AGE);
        end
        r.hit  = found;
        r.slot = slot[3:0];
        r.hits = dir_hits;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_r.hit     = m_tdata[0];
            got_r.slot    = m_tdata[4:1];
            got_r.evicted = m_tdata[5];
            got_r.ev_key  = m_tdata[37:6];
            got_r.hits    = m_tdata[69:38];
            if (exp_wr == exp_rd)
            begin
                $display("%0t: result with no item waiting, expected none, got %h",
                         $time, m_tdata);
                errors++;
            end
            else
            begin
                want_r = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                check_field("hit", want_r.hit, got_r.hit);
                check_field("slot_index", want_r.slot, got_r.slot);
                check_field("evicted", want_r.evicted, got_r.evicted);
                check_field("evicted_key", want_r.ev_key, got_r.ev_key);
                check_field("hit_count", want_r.hits, got_r.hits);
                check_field("padding", 32'd0, m_tdata[71:70]);
                hits_seen   += got_r.hit;
                evicts_seen += got_r.evicted;
            end
        end
    end

    // Receiver: random ready bursts, one long hold on request, steady ready when calm.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !calm)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CY) @(posedge clk);
            end
            else if (calm || $urandom_range(0, 2) != 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    task automatic send_access(input logic st, input logic [31:0] key,
                               input logic typed, input lookup_t want);
        lookup_t pred;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= st;
        do
            @(posedge clk);
        while (!s_tready);
        pred = cache_lookup(st, key);
        exp_buf[exp_wr % EXP_DEPTH] = typed ? want : pred;
        exp_wr++;
        items_sent++;
    endtask

    // Registers change only with nothing in flight.
    task automatic write_slot_limit(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        slot_cfg  = value;
        cfg_writes++;
    endtask

    initial
    begin
        logic [31:0]      pool [2*NSLOT+1];
        int               pool_n;
        logic [CFG_W-1:0] limit_val;
        logic [31:0]      key;
        logic             st;
        int               ph;
        int               i;
        int               r;
        int               lim;
        int               wait_cy;
        errors      = 0;
        items_sent  = 0;
        hits_seen   = 0;
        evicts_seen = 0;
        cfg_writes  = 0;
        cycles      = 0;
        exp_wr      = 0;
        exp_rd      = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        dir_filled  = 0;
        dir_hits    = '0;
        slot_cfg    = ACTIVE_RESET;
        for (i = 0; i < NSLOT; i++)
        begin
            dir_key[i]  = '0;
            dir_rank[i] = 0;
        end
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NROWS; i++)
        begin
            if (STIM[i].kind == ROW_CFG)
                write_slot_limit(STIM[i].cfg);
            else
                send_access(STIM[i].st, STIM[i].key, STIM[i].typed, STIM[i].want);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 6)
                0: limit_val = 5'd1;
                1: limit_val = 5'($urandom_range(2, 6));
                2: limit_val = 5'd16;
                3: limit_val = 5'd0;
                4: limit_val = 5'd31;
                default: limit_val = 5'($urandom_range(0, 31));
            endcase
            calm = (ph >= PHASES - 2);
            write_slot_limit(limit_val);
            if (ph == 3)
                hold_req = 1'b1;
            lim = (limit_val == 0) ? 1 : ((limit_val > NSLOT) ? NSLOT : int'(limit_val));
            // A pool a bit larger than the cache gives a mix of hits and evictions.
            pool_n = lim + int'($urandom_range(1, lim + 1));
            for (i = 0; i < pool_n; i++)
                pool[i] = $urandom();
            for (i = 0; i < PER_PH; i++)
            begin
                r   = $urandom_range(0, 99);
                key = pool[$urandom_range(0, pool_n - 1)];
                st  = (i == 0) ? ($urandom_range(0, 2) == 0) : (r < 2);
                if (r >= 2 && r < 10)
                    key = $urandom();
                send_access(st, key, 1'b0, NO_WANT);
            end
        end

        s_tvalid <= 1'b0;
        wait_cy = 0;
        while (exp_wr != exp_rd && wait_cy < 5000)
        begin
            @(posedge clk);
            wait_cy++;
        end
        repeat (40) @(posedge clk);
        if (exp_wr != exp_rd)
        begin
            $display("%0t: %0d results missing, expected 0 outstanding, got %0d",
                     $time, exp_wr - exp_rd, exp_wr - exp_rd);
            errors++;
        end
        $display("Covered %0d lookups under %0d slot-limit writes (0, 1, 16, 31 and others),",
                 items_sent, cfg_writes);
        $display("with %0d hits, %0d evictions, run restarts and a long output stall.",
                 hits_seen, evicts_seen);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
